[hdl/xoshiro256ss_prng_with_range_defines.svh]
// Assertion macros shared by the RTL.
`ifndef XOSHIRO256SS_PRNG_WITH_RANGE_DEFINES_SVH
`define XOSHIRO256SS_PRNG_WITH_RANGE_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define XSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("xss assertion failed");
// next-cycle implication
`define XSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("xss assertion failed");
`else
`define XSS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define XSS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hdl/xss_pkg.sv]
`default_nettype none

package xss_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned HALF_W = WORD_W / 2;

    localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;

    typedef enum logic [1:0] {
        CMD_DRAW64   = 2'd0,
        CMD_DRAW_HI  = 2'd1,
        CMD_DRAW_MOD = 2'd2,
        CMD_RESEED   = 2'd3
    } t_cmd;

    // one restoring-remainder step: shift in one dividend bit, subtract if it fits
    function automatic logic [HALF_W-1:0] rem_step(
        input logic [HALF_W-1:0] rem,
        input logic              bit_in,
        input logic [HALF_W-1:0] divisor
    );
        logic [HALF_W:0] t;
        logic [HALF_W:0] d;
        t = {rem, bit_in};
        d = {1'b0, divisor};
        if (t >= d) begin
            t = t - d;
        end
        return t[HALF_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hdl/xss_mul64.sv]
`default_nettype none

// 64x64 -> low 64 multiply on one 32x32 multiplier, four steps.
module xss_mul64
    import xss_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [WORD_W-1:0] i_a,
    input  wire logic [WORD_W-1:0] i_b,
    output logic                   o_done,
    output logic [WORD_W-1:0]      o_prod
);

    logic              r_busy;
    logic              r_done;
    logic [1:0]        r_step;
    logic [WORD_W-1:0] r_a;
    logic [WORD_W-1:0] r_b;
    logic [WORD_W-1:0] r_pp;
    logic [WORD_W-1:0] r_acc;

    logic [HALF_W-1:0] w_opa;
    logic [HALF_W-1:0] w_opb;
    logic [WORD_W-1:0] w_pp;

    // step 0: lo*lo, step 1: lo*hi, step 2: hi*lo (cross terms only need low half)
    always_comb begin
        w_opa = r_a[HALF_W-1:0];
        w_opb = r_b[HALF_W-1:0];
        if (r_step == 2'd1) begin
            w_opb = r_b[WORD_W-1:HALF_W];
        end else if (r_step == 2'd2) begin
            w_opa = r_a[WORD_W-1:HALF_W];
        end
    end

    assign w_pp = w_opa * w_opb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            // done pulses with the last accumulate
            r_done <= !i_start && r_busy && (r_step == 2'd3);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
                r_a    <= i_a;
                r_b    <= i_b;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                r_pp   <= w_pp;
                case (r_step)
                    2'd0: r_acc <= '0;
                    2'd1: r_acc <= r_pp;
                    2'd2: r_acc <= r_acc + {r_pp[HALF_W-1:0], {HALF_W{1'b0}}};
                    2'd3: begin
                        r_acc  <= r_acc + {r_pp[HALF_W-1:0], {HALF_W{1'b0}}};
                        r_busy <= 1'b0;
                    end
                    default: r_acc <= r_acc;
                endcase
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

[hdl/xss_divrem.sv]
`default_nettype none

// 64-bit by 32-bit remainder, restoring, two quotient bits per cycle.
module xss_divrem
    import xss_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [WORD_W-1:0] i_dividend,
    input  wire logic [HALF_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [HALF_W-1:0]      o_rem
);

    localparam int unsigned STEPS = WORD_W / 2;
    localparam int unsigned CNT_W = $clog2(STEPS);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_num;
    logic [HALF_W-1:0] r_rem;
    logic [HALF_W-1:0] r_div;

    logic [HALF_W-1:0] w_rem1;
    logic [HALF_W-1:0] w_rem2;

    assign w_rem1 = rem_step(r_rem, r_num[WORD_W-1], r_div);
    assign w_rem2 = rem_step(w_rem1, r_num[WORD_W-2], r_div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CNT_W'(STEPS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_rem2;
                r_num <= {r_num[WORD_W-3:0], 2'b00};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

[hdl/xoshiro256ss_prng_with_range.sv]
// From transfer in to result valid: a 64-bit or upper-half draw passes MUL5, MUL9 and
// OUT, a zero bound goes straight to OUT, a modulo draw also waits on the remainder unit
// (32 two-bit steps), and a reseed runs four mixes, each two 4-step multiplies on one
// 32x32 multiplier, then the seed fix. Only one request is in flight; the next is
// taken the cycle after the result is registered, which can wait on a full result register.
// Reset (synchronous, active low): state words, draw count and seed register cleared.
`default_nettype none
`include "xoshiro256ss_prng_with_range_defines.svh"

module xoshiro256ss_prng_with_range
    import xss_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // request channel
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [1:0]        i_cmd,
    input  wire logic [HALF_W-1:0] i_bound,
    // result channel
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [WORD_W-1:0]      o_value,
    output logic [WORD_W-1:0]      o_draw_count,
    output logic [WORD_W-1:0]      o_word0,
    output logic [WORD_W-1:0]      o_word1,
    output logic [WORD_W-1:0]      o_word2,
    output logic [WORD_W-1:0]      o_word3,
    // seed register write
    input  wire logic              i_cfg_wr_en,
    input  wire logic [WORD_W-1:0] i_cfg_wr_data
);

    // Sequencer. Draws use shifts/adds (x*5, x*9), the modulo runs on the
    // remainder unit, the reseed mixes run on the shared multiplier.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DRAW_MUL5,
        S_DRAW_MUL9,
        S_MOD_WAIT,
        S_MIX_ADD,
        S_MIX_XS1,
        S_MIX_WAIT1,
        S_MIX_XS2,
        S_MIX_WAIT2,
        S_SEED_FIX,
        S_OUT
    } t_state;

    t_state            r_state;
    t_cmd              r_cmd;
    logic [HALF_W-1:0] r_bound;
    logic [WORD_W-1:0] r_seed;
    logic [WORD_W-1:0] r_w [4];
    logic [WORD_W-1:0] r_draws;
    logic [WORD_W-1:0] r_val;       // scratch: draw result or mix value
    logic [1:0]        r_mix_cnt;   // which state word the current mix fills
    logic              r_mul_start;
    logic              r_div_start;

    logic              r_o_valid;
    logic [WORD_W-1:0] r_o_value;
    logic [WORD_W-1:0] r_o_draws;
    logic [WORD_W-1:0] r_o_w [4];

    logic              w_mul_done;
    logic [WORD_W-1:0] w_mul_prod;
    logic [WORD_W-1:0] w_mul_b;
    logic              w_div_done;
    logic [HALF_W-1:0] w_div_rem;

    logic [WORD_W-1:0] w_r5;        // rotl(w1 * 5, 7)
    logic [WORD_W-1:0] w_r9;        // scratch * 9
    logic [WORD_W-1:0] w_nw [4];    // xoshiro256 next state
    logic [WORD_W-1:0] w_t;
    logic [WORD_W-1:0] w_mix_out;
    logic              w_out_free;

    // ------------------------------------------------------------------
    // Datapath pieces
    // ------------------------------------------------------------------
    always_comb begin
        logic [WORD_W-1:0] m5;
        m5   = r_w[1] + {r_w[1][WORD_W-3:0], 2'b00};
        w_r5 = {m5[WORD_W-8:0], m5[WORD_W-1:WORD_W-7]};
    end

    assign w_r9 = r_val + {r_val[WORD_W-4:0], 3'b000};

    always_comb begin
        logic [WORD_W-1:0] n3;
        w_t     = {r_w[1][WORD_W-18:0], 17'd0};
        w_nw[2] = r_w[2] ^ r_w[0];
        n3      = r_w[3] ^ r_w[1];
        w_nw[1] = r_w[1] ^ w_nw[2];
        w_nw[0] = r_w[0] ^ n3;
        w_nw[2] = w_nw[2] ^ w_t;
        w_nw[3] = {n3[WORD_W-46:0], n3[WORD_W-1:WORD_W-45]};
    end

    assign w_mix_out = w_mul_prod ^ (w_mul_prod >> 31);

    // constant operand follows the mix phase
    assign w_mul_b = (r_state == S_MIX_WAIT2) ? MIX_MUL_B : MIX_MUL_A;

    xss_mul64 u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_val),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    xss_divrem u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_val),
        .i_divisor  (r_bound),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    // result register can take a new result this cycle
    assign w_out_free = !r_o_valid || i_ready;

    // ------------------------------------------------------------------
    // Sequencer, state and result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seed      <= '0;
            r_w[0]      <= '0;
            r_w[1]      <= '0;
            r_w[2]      <= '0;
            r_w[3]      <= '0;
            r_draws     <= '0;
            r_mix_cnt   <= '0;
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            // unit start pulses leave the states that load their operands
            r_mul_start <= (r_state == S_MIX_XS1) || (r_state == S_MIX_XS2);
            r_div_start <= (r_state == S_DRAW_MUL9) && (r_cmd == CMD_DRAW_MOD);

            // set on a new result, held until the transfer out
            r_o_valid <= (r_state == S_OUT && w_out_free) || (r_o_valid && !i_ready);

            if (i_cfg_wr_en) begin
                r_seed <= i_cfg_wr_data;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd   <= t_cmd'(i_cmd);
                        r_bound <= i_bound;
                        case (t_cmd'(i_cmd))
                            CMD_RESEED: begin
                                r_val     <= r_seed;
                                r_mix_cnt <= '0;
                                r_state   <= S_MIX_ADD;
                            end
                            CMD_DRAW_MOD: begin
                                if (i_bound == '0) begin
                                    // zero bound: no advance, value 0
                                    r_val   <= '0;
                                    r_state <= S_OUT;
                                end else begin
                                    r_state <= S_DRAW_MUL5;
                                end
                            end
                            default: r_state <= S_DRAW_MUL5;
                        endcase
                    end
                end

                S_DRAW_MUL5: begin
                    r_val   <= w_r5;
                    r_state <= S_DRAW_MUL9;
                end

                S_DRAW_MUL9: begin
                    r_w[0]  <= w_nw[0];
                    r_w[1]  <= w_nw[1];
                    r_w[2]  <= w_nw[2];
                    r_w[3]  <= w_nw[3];
                    r_draws <= r_draws + WORD_W'(1);
                    case (r_cmd)
                        CMD_DRAW_HI: begin
                            r_val   <= {{HALF_W{1'b0}}, w_r9[WORD_W-1:HALF_W]};
                            r_state <= S_OUT;
                        end
                        CMD_DRAW_MOD: begin
                            r_val   <= w_r9;
                            r_state <= S_MOD_WAIT;
                        end
                        default: begin
                            r_val   <= w_r9;
                            r_state <= S_OUT;
                        end
                    endcase
                end

                S_MOD_WAIT: begin
                    if (w_div_done) begin
                        r_val   <= {{HALF_W{1'b0}}, w_div_rem};
                        r_state <= S_OUT;
                    end
                end

                S_MIX_ADD: begin
                    r_val   <= r_val + GOLDEN_GAMMA;
                    r_state <= S_MIX_XS1;
                end

                S_MIX_XS1: begin
                    r_val   <= r_val ^ (r_val >> 30);
                    r_state <= S_MIX_WAIT1;
                end

                S_MIX_WAIT1: begin
                    if (w_mul_done) begin
                        r_val   <= w_mul_prod;
                        r_state <= S_MIX_XS2;
                    end
                end

                S_MIX_XS2: begin
                    r_val   <= r_val ^ (r_val >> 27);
                    r_state <= S_MIX_WAIT2;
                end

                S_MIX_WAIT2: begin
                    if (w_mul_done) begin
                        // chained: this output seeds the next mix
                        r_w[r_mix_cnt] <= w_mix_out;
                        r_val          <= w_mix_out;
                        r_mix_cnt      <= r_mix_cnt + 2'd1;
                        r_state        <= (r_mix_cnt == 2'd3) ? S_SEED_FIX : S_MIX_ADD;
                    end
                end

                S_SEED_FIX: begin
                    if ((r_w[0] | r_w[1] | r_w[2] | r_w[3]) == '0) begin
                        r_w[0] <= GOLDEN_GAMMA;
                    end
                    r_draws <= '0;
                    r_val   <= '0;
                    r_state <= S_OUT;
                end

                S_OUT: begin
                    if (w_out_free) begin
                        r_o_value <= r_val;
                        r_o_draws <= r_draws;
                        r_o_w[0]  <= r_w[0];
                        r_o_w[1]  <= r_w[1];
                        r_o_w[2]  <= r_w[2];
                        r_o_w[3]  <= r_w[3];
                        r_state   <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_value      = r_o_value;
    assign o_draw_count = r_o_draws;
    assign o_word0      = r_o_w[0];
    assign o_word1      = r_o_w[1];
    assign o_word2      = r_o_w[2];
    assign o_word3      = r_o_w[3];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // units only finish while the sequencer waits on them
    `XSS_ASSERT_IMP(a_done_not_idle, i_clk, i_rst_n, (w_mul_done || w_div_done), !o_ready)
    // a reseed never leaves the generator stuck at all zero
    `XSS_ASSERT_IMP(a_seed_nonzero, i_clk, i_rst_n,
                    (r_state == S_OUT && r_cmd == CMD_RESEED),
                    ((r_w[0] | r_w[1] | r_w[2] | r_w[3]) != '0))
    // each advance bumps the draw count by one
    `XSS_ASSERT_NXT(a_draw_count, i_clk, i_rst_n, (r_state == S_DRAW_MUL9),
                    (r_draws == $past(r_draws) + WORD_W'(1)))
    // a transfer in always starts work
    `XSS_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, (i_valid && o_ready), !o_ready)

endmodule

`default_nettype wire

[tb/sv/tb.sv]
module tb;
    import xss_pkg::*;

    // Cycles with no transfer on either channel and no seed write before the run is
    // declared hung. Worst legal quiet stretch: the long receiver hold-off plus a
    // reseed plus a sender gap; this is several times that.
    localparam int unsigned HANG_LIMIT = 4000;
    localparam int unsigned HOLD_OFF_CYCLES = 600;
    localparam int unsigned HOLD_OFF_AT = 150;   // result index where the hold-off starts
    localparam int unsigned RANDOM_PHASES = 10;
    localparam int unsigned PHASE_ITEMS = 143;
    localparam int unsigned DRAIN_CYCLES = 64;   // longer than the slowest request

    typedef struct {
        bit [WORD_W-1:0] value;
        bit [WORD_W-1:0] draw_count;
        bit [WORD_W-1:0] word [4];
    } t_draw_result;

    // Tracks the generator state and seed register, and queues one expected result per
    // accepted request.
    class prng_scoreboard;
        bit [WORD_W-1:0] seed;
        bit [WORD_W-1:0] gen_word [4];
        bit [WORD_W-1:0] draw_total;
        t_draw_result    pending_results [$];
        int unsigned     errors;

        function new();
            seed = '0;
            gen_word = '{default: '0};
            draw_total = '0;
            errors = 0;
        endfunction

        function void write_seed(bit [WORD_W-1:0] v);
            seed = v;
        endfunction

        function bit [WORD_W-1:0] rotl(bit [WORD_W-1:0] x, int unsigned k);
            return (x << k) | (x >> (WORD_W - k));
        endfunction

        function bit [WORD_W-1:0] splitmix64(bit [WORD_W-1:0] x);
            bit [WORD_W-1:0] z;
            z = x + GOLDEN_GAMMA;
            z = (z ^ (z >> 30)) * MIX_MUL_A;
            z = (z ^ (z >> 27)) * MIX_MUL_B;
            return z ^ (z >> 31);
        endfunction

        // xoshiro256** output and state advance
        function bit [WORD_W-1:0] next_draw();
            bit [WORD_W-1:0] r;
            bit [WORD_W-1:0] t;
            r = rotl(gen_word[1] * 64'd5, 7) * 64'd9;
            t = gen_word[1] << 17;
            gen_word[2] ^= gen_word[0];
            gen_word[3] ^= gen_word[1];
            gen_word[1] ^= gen_word[2];
            gen_word[0] ^= gen_word[3];
            gen_word[2] ^= t;
            gen_word[3] = rotl(gen_word[3], 45);
            draw_total += 1;
            return r;
        endfunction

        function void note_request(t_cmd cmd, bit [HALF_W-1:0] bound);
            t_draw_result r;
            bit [WORD_W-1:0] v;
            r.value = '0;
            case (cmd)
                CMD_DRAW64: r.value = next_draw();
                CMD_DRAW_HI: r.value = next_draw() >> HALF_W;
                CMD_DRAW_MOD: begin
                    // zero bound: value 0, state and count untouched
                    if (bound != 0) r.value = next_draw() % {{HALF_W{1'b0}}, bound};
                end
                default: begin
                    v = seed;
                    for (int i = 0; i < 4; i++) begin
                        v = splitmix64(v);
                        gen_word[i] = v;
                    end
                    if ((gen_word[0] | gen_word[1] | gen_word[2] | gen_word[3]) == '0)
                        gen_word[0] = GOLDEN_GAMMA;
                    draw_total = '0;
                end
            endcase
            r.draw_count = draw_total;
            r.word = gen_word;
            pending_results.push_back(r);
        endfunction

        function void compare(string field, bit [WORD_W-1:0] want, logic [WORD_W-1:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %h, got %h", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [WORD_W-1:0] value, logic [WORD_W-1:0] count,
                                   logic [WORD_W-1:0] w0, logic [WORD_W-1:0] w1,
                                   logic [WORD_W-1:0] w2, logic [WORD_W-1:0] w3);
            t_draw_result want;
            logic [WORD_W-1:0] got_word [4];
            if (pending_results.size() == 0) begin
                $error("result transfer with no request outstanding: value %h", value);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            got_word = '{w0, w1, w2, w3};
            compare("value", want.value, value);
            compare("draw_count", want.draw_count, count);
            for (int i = 0; i < 4; i++)
                compare($sformatf("word%0d", i), want.word[i], got_word[i]);
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid;
    logic              req_ready;
    logic [1:0]        req_cmd;
    logic [HALF_W-1:0] req_bound;
    logic              res_valid;
    logic              res_ready;
    logic [WORD_W-1:0] res_value;
    logic [WORD_W-1:0] res_draw_count;
    logic [WORD_W-1:0] res_word0;
    logic [WORD_W-1:0] res_word1;
    logic [WORD_W-1:0] res_word2;
    logic [WORD_W-1:0] res_word3;
    logic              cfg_wr_en;
    logic [WORD_W-1:0] cfg_wr_data;

    // per-phase switches for back-to-back stretches on either side
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    int unsigned quiet_cycles = 0;

    prng_scoreboard sb = new();

    xoshiro256ss_prng_with_range uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (req_valid),
        .o_ready       (req_ready),
        .i_cmd         (req_cmd),
        .i_bound       (req_bound),
        .o_valid       (res_valid),
        .i_ready       (res_ready),
        .o_value       (res_value),
        .o_draw_count  (res_draw_count),
        .o_word0       (res_word0),
        .o_word1       (res_word1),
        .o_word2       (res_word2),
        .o_word3       (res_word3),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    always #5 clk = ~clk;

    // Monitor. Outputs are sampled at the edge, before this edge's updates land.
    // The result is checked before the request is noted: a result in the same cycle
    // always belongs to an earlier request.
    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready)
            sb.check_result(res_value, res_draw_count, res_word0, res_word1,
                            res_word2, res_word3);
        if (rst_n && req_valid && req_ready)
            sb.note_request(t_cmd'(req_cmd), req_bound);
    end

    // Hang detector: counts cycles with nothing moving.
    always @(posedge clk) begin
        if ((req_valid && req_ready) || (res_valid && res_ready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: random stall per transfer, with one long hold-off so the
    // single request in flight backs up and o_ready drops for a long time.
    initial begin
        int unsigned stall;
        int unsigned taken;
        res_ready <= 1'b0;
        taken = 0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (taken == HOLD_OFF_AT) stall = HOLD_OFF_CYCLES;
            else stall = rx_calm ? 0 : $urandom_range(0, 13);
            if (stall != 0) begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
            taken++;
        end
    end

    // One request transfer. A zero gap keeps valid high straight into the next
    // request, so valid is never dropped and raised in the same step.
    task automatic send_request(t_cmd cmd, bit [HALF_W-1:0] bound);
        int unsigned gap;
        gap = tx_calm ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_cmd   <= cmd;
        req_bound <= bound;
        do @(posedge clk); while (!req_ready);
    endtask

    // Stop offering and wait for every outstanding result. The first edge lets the
    // monitor record a request accepted in the current step.
    task automatic drain();
        req_valid <= 1'b0;
        do @(posedge clk); while (sb.pending_results.size() != 0);
    endtask

    // Seed register write; only called with nothing in flight.
    task automatic write_seed(bit [WORD_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        sb.write_seed(v);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic bit [HALF_W-1:0] pick_bound();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return '0;
        else if (sel <= 5) return $urandom_range(1, 16);
        else if (sel <= 8) return 32'd1 << $urandom_range(0, 31);
        else if (sel == 9) return 32'hFFFF_FFFF - $urandom_range(0, 3);
        else return $urandom;
    endfunction

    task automatic random_requests(int unsigned count);
        int unsigned pick;
        t_cmd cmd;
        for (int unsigned n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 7) cmd = CMD_RESEED;
            else if (pick < 35) cmd = CMD_DRAW64;
            else if (pick < 60) cmd = CMD_DRAW_HI;
            else cmd = CMD_DRAW_MOD;
            send_request(cmd, pick_bound());
        end
    endtask

    initial begin
        bit [WORD_W-1:0] seed_val;
        rst_n       <= 1'b0;
        req_valid   <= 1'b0;
        req_cmd     <= CMD_DRAW64;
        req_bound   <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Unseeded: words are all zero, draws give 0 but still bump the count.
        // A zero bound leaves the count alone.
        send_request(CMD_DRAW64, 32'd0);
        send_request(CMD_DRAW_HI, 32'hFFFF_FFFF);
        send_request(CMD_DRAW_MOD, 32'd5);
        send_request(CMD_DRAW_MOD, 32'd0);
        drain();

        // Seed of zero, then each command and the bound extremes. The second
        // reseed clears the count and lands on the same words.
        write_seed('0);
        send_request(CMD_RESEED, 32'd0);
        send_request(CMD_DRAW64, 32'd0);
        send_request(CMD_DRAW_HI, 32'd0);
        send_request(CMD_DRAW_MOD, 32'd1);
        send_request(CMD_DRAW_MOD, 32'hFFFF_FFFF);
        send_request(CMD_DRAW_MOD, 32'd0);
        send_request(CMD_DRAW_MOD, 32'h8000_0000);
        send_request(CMD_DRAW_MOD, 32'd7);
        send_request(CMD_RESEED, 32'hFFFF_FFFF);
        drain();

        // All-ones seed. The all-zero-words fallback cannot be hit: the mix is a
        // bijection and mix(0) is non-zero, so four chained outputs are never all zero.
        write_seed({WORD_W{1'b1}});
        send_request(CMD_RESEED, 32'd0);
        send_request(CMD_DRAW64, 32'd0);
        send_request(CMD_DRAW_HI, 32'd0);
        send_request(CMD_DRAW_MOD, 32'd2);
        send_request(CMD_DRAW_MOD, 32'hFFFF_FFFE);
        drain();

        write_seed(64'h8000_0000_0000_0001);
        send_request(CMD_RESEED, 32'd0);
        send_request(CMD_DRAW64, 32'd0);
        drain();

        // Random phases, each under its own seed; most start with a reseed so the
        // draws run from fresh state, the rest continue from the previous words.
        for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 0) seed_val = '0;
            else if (ph == RANDOM_PHASES - 1) seed_val = {WORD_W{1'b1}};
            else if (ph == 4) seed_val = 64'd1;
            else seed_val = {$urandom, $urandom};
            write_seed(seed_val);
            tx_calm = (ph % 3 == 1);
            rx_calm = (ph % 4 == 2);
            if ($urandom_range(0, 3) != 0) send_request(CMD_RESEED, $urandom);
            random_requests(PHASE_ITEMS);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/xss_pkg.sv
hdl/xss_mul64.sv
hdl/xss_divrem.sv
hdl/xoshiro256ss_prng_with_range.sv
tb/sv/tb.sv
